// ===== hdl/md3_pkg.sv =====
`default_nettype none

package md3_pkg;

  localparam int PIXEL_W           = 32;
  localparam int FRAME_WIDTH_W     = 13;
  localparam int FRAME_HEIGHT_W    = 16;
  localparam int ROW_W             = FRAME_HEIGHT_W + 1;
  localparam int CFG_INDEX_W       = 2;
  localparam int FRAME_WIDTH_RESET = 4096;
  localparam int WIN_HIST_W        = 6;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MASK_VALUE   = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_t;

  // control that travels with a request from the address stage to the window stage
  typedef struct packed {
    logic c_zero;
    logic r_ge1;
    logic r_ge2;
    logic bot;
    logic upd;
    logic last;
  } md3_ctl_t;

  // +0 and -0 compare equal
  function automatic logic is_masked(input logic [PIXEL_W-1:0] px,
                                     input logic [PIXEL_W-1:0] mv);
    logic [PIXEL_W-1:0] both;
    both = px | mv;
    return (px == mv) || (both[PIXEL_W-2:0] == '0);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/md3_ram.sv =====
`default_nettype none

module md3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/mask_dilate_3x3_top.sv =====
// an accepted request passes the window stage register and then the output register
// throughput: one request per cycle unless out_stall holds the window stage, set by the
//   read/write of the pixel delay memory and the mask row memory
// results lag the pixel stream by frame width + 1 requests; flush requests drain them
// reset (synchronous, rst_n low): counters, window and valids cleared, registers to
//   defaults; memories are not cleared and need no clearing pass
`default_nettype none

module mask_dilate_3x3_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [md3_pkg::PIXEL_W-1:0]        in_pixel_in,
  input  wire logic                               in_flush,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [md3_pkg::PIXEL_W-1:0]        out_pixel_out,
  output logic                                    out_frame_end,
  input  wire logic                               cfg_we,
  input  wire logic [md3_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [md3_pkg::PIXEL_W-1:0]        cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = md3_pkg::ROW_W;
  localparam int RST_WM1 =
    ((MAX_WIDTH < md3_pkg::FRAME_WIDTH_RESET) ? MAX_WIDTH : md3_pkg::FRAME_WIDTH_RESET) - 1;

  // configuration
  logic [md3_pkg::PIXEL_W-1:0]        mask_value_r;
  logic [CW-1:0]                      width_m1_r, width_m1_nxt;
  logic [md3_pkg::FRAME_HEIGHT_W-1:0] height_r, height_nxt;
  logic                               restart;
  logic [md3_pkg::FRAME_WIDTH_W-1:0]  fw;
  logic [md3_pkg::FRAME_HEIGHT_W-1:0] fh;

  // position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [WW-1:0] slot_r, slot_nxt;

  // address stage
  logic              h_ext_unused;
  logic [RW-1:0]     h_ext;
  logic              in_frame, at_last, col_last, slot_last, accept, proc;
  md3_pkg::md3_ctl_t ctl;

  // window stage
  logic                           s1_valid_r, s1_valid_nxt;
  md3_pkg::md3_ctl_t              s1_ctl_r;
  logic [CW-1:0]                  s1_col_r;
  logic                           s1_fire;
  logic [md3_pkg::WIN_HIST_W-1:0] window_r, window_nxt;
  logic [2:0]                     triple;
  logic [8:0]                     win;
  logic                           top, mid, have_out;
  logic [1:0]                     rows_rd;
  logic [md3_pkg::PIXEL_W-1:0]    delayed;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [md3_pkg::PIXEL_W-1:0] out_pixel_r;
  logic                        out_frame_end_r;

  assign h_ext_unused = 1'b0;

  assign fw = cfg_wdata[md3_pkg::FRAME_WIDTH_W-1:0];
  assign fh = cfg_wdata[md3_pkg::FRAME_HEIGHT_W-1:0];

  always_comb begin
    restart      = 1'b0;
    width_m1_nxt = width_m1_r;
    height_nxt   = height_r;
    if (cfg_we) begin
      case (cfg_index)
        md3_pkg::CFG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (32'(fw) > 32'(MAX_WIDTH)) begin
            width_m1_nxt = CW'(MAX_WIDTH - 1);
          end else if (fw < md3_pkg::FRAME_WIDTH_W'(2)) begin
            width_m1_nxt = CW'(1);
          end else begin
            width_m1_nxt = CW'(32'(fw) - 32'd1);
          end
        end
        md3_pkg::CFG_FRAME_HEIGHT: begin
          restart    = 1'b1;
          height_nxt = (fh == '0) ? md3_pkg::FRAME_HEIGHT_W'(1) : fh;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_value_r <= '0;
      width_m1_r   <= CW'(RST_WM1);
      height_r     <= md3_pkg::FRAME_HEIGHT_W'(1);
    end else begin
      if (cfg_we && (cfg_index == md3_pkg::CFG_MASK_VALUE)) begin
        mask_value_r <= cfg_wdata;
      end
      width_m1_r <= width_m1_nxt;
      height_r   <= height_nxt;
    end
  end

  // address stage
  assign h_ext     = {h_ext_unused, height_r};
  assign in_frame  = row_r < h_ext;
  assign at_last   = row_r == (h_ext + RW'(1));
  assign col_last  = col_r == width_m1_r;
  assign slot_last = slot_r == (WW'(width_m1_r) + WW'(1));

  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign accept   = in_valid && !in_stall;
  // an early flush is taken and dropped
  assign proc     = accept && !(in_frame && in_flush);

  always_comb begin
    ctl.c_zero = col_r == '0;
    ctl.r_ge1  = row_r >= RW'(1);
    ctl.r_ge2  = row_r >= RW'(2);
    ctl.bot    = in_frame && md3_pkg::is_masked(in_pixel_in, mask_value_r);
    ctl.upd    = row_r <= h_ext;
    ctl.last   = at_last;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    if (restart || (proc && at_last)) begin
      col_nxt  = '0;
      row_nxt  = '0;
      slot_nxt = '0;
    end else if (proc) begin
      slot_nxt = slot_last ? '0 : slot_r + WW'(1);
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

  // pixel delay line, read-first on the same slot
  md3_ram #(
    .WIDTH(md3_pkg::PIXEL_W),
    .DEPTH(MAX_WIDTH + 1)
  ) u_delay_ram (
    .clk  (clk),
    .we   (proc && in_frame),
    .waddr(slot_r),
    .wdata(in_pixel_in),
    .re   (proc),
    .raddr(slot_r),
    .rdata(delayed)
  );

  // mask bits of the two rows above: bit 1 two rows back, bit 0 one row back
  md3_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_rows_ram (
    .clk  (clk),
    .we   (s1_fire && s1_ctl_r.upd),
    .waddr(s1_col_r),
    .wdata({mid, s1_ctl_r.bot}),
    .re   (proc),
    .raddr(col_r),
    .rdata(rows_rd)
  );

  // window stage
  always_comb begin
    if (proc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      s1_ctl_r <= ctl;
      s1_col_r <= col_r;
    end
  end

  assign top    = s1_ctl_r.r_ge2 && rows_rd[1];
  assign mid    = s1_ctl_r.r_ge1 && rows_rd[0];
  assign triple = {top, mid, s1_ctl_r.bot};

  always_comb begin
    if (s1_ctl_r.c_zero) begin
      win      = {window_r, 3'b000};
      have_out = s1_ctl_r.r_ge2;
    end else begin
      win      = {window_r, triple};
      have_out = s1_ctl_r.r_ge1;
    end
    window_nxt = window_r;
    if (restart || (s1_fire && s1_ctl_r.last)) begin
      window_nxt = '0;
    end else if (s1_fire && s1_ctl_r.upd) begin
      window_nxt = s1_ctl_r.c_zero ? {3'b000, triple} : {window_r[2:0], triple};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else begin
      window_r <= window_nxt;
    end
  end

  // output register
  always_comb begin
    if (s1_fire && have_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && have_out) begin
      out_pixel_r     <= (win != '0) ? mask_value_r : delayed;
      out_frame_end_r <= s1_ctl_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_frame_end = out_frame_end_r;

  // checks
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= width_m1_r)
    else $error("column counter past row end");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= (h_ext + RW'(1)))
    else $error("row counter past flush row");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= (WW'(width_m1_r) + WW'(1)))
    else $error("delay slot past frame width");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && at_last) |=> (row_r == '0 && col_r == '0 && slot_r == '0))
    else $error("frame did not restart after last request");

  a_last_at_col0: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ctl_r.last) |-> s1_ctl_r.c_zero)
    else $error("frame end away from column zero");

endmodule

`default_nettype wire

// ===== bench/tb_mask_dilate_3x3_top.sv =====
`timescale 1ns / 100ps

module tb_mask_dilate_3x3_top;

  localparam int MAX_W          = 4096;
  localparam int IDLE_PCT       = 17;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1750;
  localparam int TAIL_ITEMS     = 150;

  typedef struct {
    logic [md3_pkg::PIXEL_W-1:0] pixel;
    bit                          flush;
  } pixel_req_t;

  typedef struct {
    logic [md3_pkg::PIXEL_W-1:0] pixel;
    bit                          frame_end;
  } dilated_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [md3_pkg::PIXEL_W-1:0]        in_pixel_in = '0;
  logic                               in_flush = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [md3_pkg::PIXEL_W-1:0]        out_pixel_out;
  logic                               out_frame_end;
  logic                               cfg_we = 1'b0;
  logic [md3_pkg::CFG_INDEX_W-1:0]    cfg_index = md3_pkg::CFG_MASK_VALUE;
  logic [md3_pkg::PIXEL_W-1:0]        cfg_wdata = '0;

  pixel_req_t feed_q[$];
  dilated_t   dilated_q[$];

  // dilation state
  logic [md3_pkg::PIXEL_W-1:0]        mask_word = '0;
  logic [md3_pkg::FRAME_WIDTH_W-1:0]  width_reg = 13'd4096;
  logic [md3_pkg::FRAME_HEIGHT_W-1:0] height_reg = 16'd1;
  bit [md3_pkg::PIXEL_W-1:0]          pixel_line [0:MAX_W];
  bit                                 above_row [MAX_W];
  bit                                 current_row [MAX_W];
  bit [8:0]                           win_cols = '0;
  int unsigned                        col_pos = 0;
  int unsigned                        row_pos = 0;

  int  errors = 0;
  int  items_fed = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 1'b0;
  bit  calm = 1'b0;
  bit  need_restart = 1'b0;

  mask_dilate_3x3_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_in   (in_pixel_in),
    .in_flush      (in_flush),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned span_w();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned span_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic bit is_mask_word(input logic [md3_pkg::PIXEL_W-1:0] px);
    logic [md3_pkg::PIXEL_W-1:0] both;
    both = px | mask_word;
    return (px == mask_word) || (both[md3_pkg::PIXEL_W-2:0] == '0);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    win_cols = '0;
  endfunction

  function automatic bit dilate_pixel(input logic [md3_pkg::PIXEL_W-1:0] px,
                                      input bit flush,
                                      output logic [md3_pkg::PIXEL_W-1:0] res,
                                      output bit frame_end);
    int unsigned w, h, r, c, slot;
    bit [8:0] win;
    bit top, mid, bot, have;
    logic [md3_pkg::PIXEL_W-1:0] delayed;
    w = span_w();
    h = span_h();
    r = row_pos;
    c = col_pos;
    have = 1'b0;
    frame_end = 1'b0;
    res = '0;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r < h && flush) return 1'b0;
    slot = (r * w + c) % (w + 1);
    delayed = pixel_line[slot];
    if (r < h) pixel_line[slot] = px;
    if (c == 0) begin
      win = {win_cols[5:0], 3'b000};
      if (r >= 2) begin
        have = 1'b1;
        frame_end = (r == h + 1);
      end
    end else begin
      win = '0;
    end
    if (r <= h) begin
      top = (r >= 2) ? above_row[c] : 1'b0;
      mid = (r >= 1) ? current_row[c] : 1'b0;
      bot = (r < h) && is_mask_word(px);
      above_row[c] = mid;
      current_row[c] = bot;
      if (c == 0) begin
        win_cols = {6'b0, top, mid, bot};
      end else begin
        win_cols = {win_cols[5:0], top, mid, bot};
        win = win_cols;
        if (r >= 1) have = 1'b1;
      end
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos = c;
    row_pos = r;
    if (!have) return 1'b0;
    res = (win != 0) ? mask_word : delayed;
    if (frame_end) restart_frame();
    return 1'b1;
  endfunction

  function automatic logic [md3_pkg::PIXEL_W-1:0] random_pixel();
    int roll;
    roll = $urandom_range(19);
    case (roll)
      0, 1: return mask_word;
      2: return mask_word ^ 32'h8000_0000;
      3: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h0000_0000;
      4: return mask_word ^ (32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [md3_pkg::PIXEL_W-1:0] random_mask();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 32'h0000_0000;
    if (roll < 40) return 32'h8000_0000;
    if (roll < 50) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic set_reg(input md3_pkg::cfg_idx_t idx,
                         input logic [md3_pkg::PIXEL_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      md3_pkg::CFG_MASK_VALUE: mask_word = value;
      md3_pkg::CFG_FRAME_WIDTH: begin
        width_reg = value[md3_pkg::FRAME_WIDTH_W-1:0];
        restart_frame();
      end
      md3_pkg::CFG_FRAME_HEIGHT: begin
        height_reg = value[md3_pkg::FRAME_HEIGHT_W-1:0];
        restart_frame();
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (feed_q.size() != 0 || in_valid || dilated_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [md3_pkg::PIXEL_W-1:0] px);
    feed_q.push_back('{pixel: px, flush: 1'b0});
    items_fed++;
  endtask

  task automatic send_flush();
    feed_q.push_back('{pixel: $urandom, flush: 1'b1});
    items_fed++;
  endtask

  task automatic feed_frame(input int cut, input int pause_at);
    int total;
    int n;
    total = (cut >= 0) ? cut : span_w() * span_h();
    for (n = 0; n < total; n++) begin
      if (n == pause_at) wait_drained();
      // a flush before the frame is complete is dropped
      if ($urandom_range(99) < 3) feed_q.push_back('{pixel: $urandom, flush: 1'b1});
      send_pixel(random_pixel());
    end
    if (cut < 0) begin
      for (n = 0; n <= span_w(); n++) begin
        if ($urandom_range(9) < 7) send_flush();
        else send_pixel(random_pixel());
      end
    end
  endtask

  // request driver, predicts results at acceptance
  always @(posedge clk) begin : drive
    bit take;
    bit got;
    logic [md3_pkg::PIXEL_W-1:0] res;
    bit frame_end;
    pixel_req_t nxt;
    if (rst_n) begin
      take = in_valid && !in_stall;
      if (take) begin
        got = dilate_pixel(in_pixel_in, in_flush, res, frame_end);
        if (got) dilated_q.push_back('{pixel: res, frame_end: frame_end});
      end
      if (!in_valid || take) begin
        if (feed_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = feed_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_in <= nxt.pixel;
          in_flush <= nxt.flush;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : watch
    bit stall_next;
    dilated_t exp_res;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (dilated_q.size() == 0) begin
          $error("unexpected result: pixel_out %h frame_end %b", out_pixel_out, out_frame_end);
          errors++;
        end else begin
          exp_res = dilated_q.pop_front();
          if (out_pixel_out !== exp_res.pixel) begin
            $error("pixel_out: expected %h, actual %h", exp_res.pixel, out_pixel_out);
            errors++;
          end
          if (out_frame_end !== exp_res.frame_end) begin
            $error("frame_end: expected %b, actual %b", exp_res.frame_end, out_frame_end);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        stall_next = 1'b1;
      end else begin
        stall_next = !calm && ($urandom_range(99) < IDLE_PCT);
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_no;
    int nframes;
    int f;
    int roll;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // clamped geometry, +0 vs -0, early flush, surplus pixel
    set_reg(md3_pkg::CFG_MASK_VALUE, 32'h0000_0000);
    set_reg(md3_pkg::CFG_FRAME_WIDTH, 32'd1);
    set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd0);
    send_flush();
    send_pixel(32'h8000_0000);
    send_flush();
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    send_flush();
    send_flush();
    wait_drained();

    // no wrap across the row edge
    set_reg(md3_pkg::CFG_MASK_VALUE, 32'hFFFF_FFFF);
    set_reg(md3_pkg::CFG_FRAME_WIDTH, 32'd3);
    set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd3);
    send_pixel(32'h0000_0000);
    send_pixel(32'h8000_0001);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0000);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'h5555_5555);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'hFFFF_FFFE);
    send_pixel(32'h0000_0001);
    repeat (4) send_flush();
    wait_drained();

    // tallest frame, cut short by a geometry write
    set_reg(md3_pkg::CFG_MASK_VALUE, 32'h8000_0000);
    set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd65535);
    set_reg(md3_pkg::CFG_FRAME_WIDTH, 32'd2);
    send_pixel(32'h0000_0000);
    send_pixel(32'h0000_0001);
    send_pixel(32'h0000_0002);
    send_pixel(32'h8000_0000);
    send_pixel(32'hFFFF_FFFF);
    wait_drained();

    // receiver holds off while requests keep coming, sender pauses mid-frame
    set_reg(md3_pkg::CFG_MASK_VALUE, random_mask());
    set_reg(md3_pkg::CFG_FRAME_WIDTH, 32'd3);
    set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd40);
    hold_req = 1'b1;
    feed_frame(-1, 60);

    phase_no = 0;
    while (items_fed < RANDOM_ITEMS - TAIL_ITEMS) begin
      wait_drained();
      calm = (phase_no == 2);
      if ($urandom_range(1) != 0) set_reg(md3_pkg::CFG_MASK_VALUE, random_mask());
      if (need_restart || $urandom_range(99) < 60) begin
        roll = $urandom_range(99);
        if (roll < 8) set_reg(md3_pkg::CFG_FRAME_WIDTH, $urandom_range(1));
        else if (roll < 80) set_reg(md3_pkg::CFG_FRAME_WIDTH, $urandom_range(8, 2));
        else set_reg(md3_pkg::CFG_FRAME_WIDTH, $urandom_range(40, 9));
      end
      if (need_restart || $urandom_range(99) < 60) begin
        roll = $urandom_range(99);
        if (roll < 8) set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd0);
        else if (roll < 85) set_reg(md3_pkg::CFG_FRAME_HEIGHT, $urandom_range(6, 1));
        else set_reg(md3_pkg::CFG_FRAME_HEIGHT, $urandom_range(16, 7));
      end
      need_restart = 1'b0;
      nframes = $urandom_range(3, 1);
      for (f = 0; f < nframes; f++) begin
        if (items_fed >= RANDOM_ITEMS - TAIL_ITEMS) break;
        if ($urandom_range(9) == 0) begin
          feed_frame($urandom_range(span_w() * span_h() - 1), -1);
          need_restart = 1'b1;
          break;
        end
        feed_frame(-1, -1);
      end
      phase_no++;
    end

    // widest frame, width and height written out of range, cut short
    wait_drained();
    set_reg(md3_pkg::CFG_MASK_VALUE, random_mask());
    set_reg(md3_pkg::CFG_FRAME_WIDTH, 32'h0000_1FFF);
    set_reg(md3_pkg::CFG_FRAME_HEIGHT, 32'd0);
    calm = 1'b1;
    feed_frame(TAIL_ITEMS, -1);
    wait_drained();

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
